>>> hw/rtl/nts_pkg.sv
// shared types and constants for the numeric table stream parser
`timescale 1ns / 1ps

package nts_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_W    = 31;
  localparam int unsigned PART_W   = 24;
  localparam int unsigned PROD_W   = 63;

  // one result item
  typedef struct packed {
    logic                     accepted;
    logic                     cell_valid;
    logic signed [WORD_W-1:0] table_num;
    logic        [CNT_W-1:0]  row;
    logic        [CNT_W-1:0]  column;
    logic signed [WORD_W-1:0] cell_value;
    logic                     finished;
  } res_t;

endpackage

>>> hw/rtl/nts_stream_if.sv
// request and result channels of the numeric table stream parser
`timescale 1ns / 1ps

interface nts_in_if;
  logic                            valid;
  logic                            ready;
  logic [nts_pkg::BYTE_W-1:0]      data_byte;
  logic                            restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface nts_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              cell_valid;
  logic signed [nts_pkg::WORD_W-1:0] table_num;
  logic        [nts_pkg::CNT_W-1:0]  row;
  logic        [nts_pkg::CNT_W-1:0]  column;
  logic signed [nts_pkg::WORD_W-1:0] cell_value;
  logic                              finished;

  modport source (output valid, output accepted, output cell_valid, output table_num,
                  output row, output column, output cell_value, output finished,
                  input ready);
  modport sink   (input valid, input accepted, input cell_valid, input table_num,
                  input row, input column, input cell_value, input finished,
                  output ready);
endinterface

>>> hw/rtl/numeric_table_stream_parser.sv
// top level of the numeric table stream parser
`timescale 1ns / 1ps
// a result shows on the output channel in the cycle after its byte is accepted
// throughput: one byte per cycle unless the output register is full and not being read
// the per-byte state update plus one 31x8 partial product sets the critical path
// reset (rst_n low, synchronous): expect table count, stream ok, all counters zero,
// output register empty

module numeric_table_stream_parser (
  input  logic      clk,
  input  logic      rst_n,
  nts_in_if.sink    in_ch,
  nts_out_if.source out_ch
);

  logic          in_fire;
  logic          can_take;
  nts_pkg::res_t core_res;
  nts_pkg::res_t buf_res;

  // a request is taken whenever the result register is empty or being drained
  assign in_ch.ready = can_take;
  assign in_fire     = in_ch.valid && can_take;

  // byte assembly, word decode and cell bookkeeping
  nts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_ch.data_byte),
    .restart   (in_ch.restart),
    .res       (core_res)
  );

  // one result register decouples the two channels
  nts_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_fire),
    .res_in    (core_res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_out   (buf_res)
  );

  assign out_ch.accepted   = buf_res.accepted;
  assign out_ch.cell_valid = buf_res.cell_valid;
  assign out_ch.table_num  = buf_res.table_num;
  assign out_ch.row        = buf_res.row;
  assign out_ch.column     = buf_res.column;
  assign out_ch.cell_value = buf_res.cell_value;
  assign out_ch.finished   = buf_res.finished;

endmodule

>>> hw/rtl/nts_core.sv
// parser state and per-byte next-state logic
`timescale 1ns / 1ps

module nts_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [nts_pkg::BYTE_W-1:0] data_byte,
  input  logic                       restart,
  output nts_pkg::res_t              res
);

  typedef enum logic [2:0] {
    PH_COUNT, PH_NUMBER, PH_ROWS, PH_COLUMNS, PH_VALUE, PH_STRLEN, PH_STRING, PH_DONE
  } phase_t;

  localparam int unsigned CW = nts_pkg::CNT_W;
  localparam int unsigned WW = nts_pkg::WORD_W;
  localparam int unsigned PW = nts_pkg::PART_W;
  localparam int unsigned XW = nts_pkg::PROD_W;
  localparam int unsigned MW = CW + nts_pkg::BYTE_W;

  phase_t          phase_r, phase_nxt, phase_c;
  logic [CW-1:0]   tables_left_r, tables_left_nxt, tables_left_c;
  logic [WW-1:0]   current_table_r, current_table_nxt, current_table_c;
  logic [CW-1:0]   row_total_r, row_total_nxt, row_total_c;
  logic [CW-1:0]   column_total_r, column_total_nxt, column_total_c;
  logic [WW-1:0]   cell_total_r, cell_total_nxt, cell_total_c;
  logic [WW-1:0]   cells_emitted_r, cells_emitted_nxt, cells_emitted_c;
  logic [CW-1:0]   row_position_r, row_position_nxt, row_position_c;
  logic [CW-1:0]   column_position_r, column_position_nxt, column_position_c;
  logic [WW-1:0]   strings_seen_r, strings_seen_nxt, strings_seen_c;
  logic [CW-1:0]   string_left_r, string_left_nxt, string_left_c;
  logic [PW-1:0]   word_partial_r, word_partial_nxt, word_partial_c;
  logic [1:0]      byte_position_r, byte_position_nxt, byte_position_c;
  logic            stream_ok_r, stream_ok_nxt, stream_ok_c;
  logic [XW-1:0]   prod_acc_r, prod_acc_nxt;

  logic [WW-1:0]   word;
  logic [MW-1:0]   byte_prod;
  logic [XW-1:0]   byte_prod_sh;
  logic [XW-1:0]   prod_full;
  logic [CW-1:0]   tables_dec;
  logic [WW-1:0]   strings_inc;
  logic [WW-1:0]   cells_inc;
  logic [CW-1:0]   column_inc;
  logic [CW-1:0]   string_dec;

  // restart behaves as a reset applied just before this byte
  assign phase_c           = restart ? PH_COUNT : phase_r;
  assign tables_left_c     = restart ? '0 : tables_left_r;
  assign current_table_c   = restart ? '0 : current_table_r;
  assign row_total_c       = restart ? '0 : row_total_r;
  assign column_total_c    = restart ? '0 : column_total_r;
  assign cell_total_c      = restart ? '0 : cell_total_r;
  assign cells_emitted_c   = restart ? '0 : cells_emitted_r;
  assign row_position_c    = restart ? '0 : row_position_r;
  assign column_position_c = restart ? '0 : column_position_r;
  assign strings_seen_c    = restart ? '0 : strings_seen_r;
  assign string_left_c     = restart ? '0 : string_left_r;
  assign word_partial_c    = restart ? '0 : word_partial_r;
  assign byte_position_c   = restart ? '0 : byte_position_r;
  assign stream_ok_c       = restart ? 1'b1 : stream_ok_r;

  assign word        = {data_byte, word_partial_c};
  assign tables_dec  = tables_left_c - CW'(1);
  assign strings_inc = strings_seen_c + WW'(1);
  assign cells_inc   = cells_emitted_c + WW'(1);
  assign column_inc  = column_position_c + CW'(1);
  assign string_dec  = (string_left_c != '0) ? string_left_c - CW'(1) : string_left_c;

  // rows*columns built one byte of the columns word at a time
  assign byte_prod    = MW'(row_total_c) * MW'(data_byte);
  assign byte_prod_sh = XW'(byte_prod) << {byte_position_c, 3'b000};
  assign prod_full    = prod_acc_r + byte_prod_sh;

  always_comb begin
    phase_nxt           = phase_c;
    tables_left_nxt     = tables_left_c;
    current_table_nxt   = current_table_c;
    row_total_nxt       = row_total_c;
    column_total_nxt    = column_total_c;
    cell_total_nxt      = cell_total_c;
    cells_emitted_nxt   = cells_emitted_c;
    row_position_nxt    = row_position_c;
    column_position_nxt = column_position_c;
    strings_seen_nxt    = strings_seen_c;
    string_left_nxt     = string_left_c;
    word_partial_nxt    = word_partial_c;
    byte_position_nxt   = byte_position_c;
    stream_ok_nxt       = stream_ok_c;
    prod_acc_nxt        = prod_acc_r;
    res                 = '0;

    if (stream_ok_c && (phase_c != PH_DONE)) begin
      res.accepted = 1'b1;
      if (phase_c == PH_STRING) begin
        string_left_nxt = string_dec;
        if (string_dec == '0) begin
          strings_seen_nxt = strings_inc;
          if (strings_inc == cell_total_c) begin
            tables_left_nxt = tables_dec;
            if (tables_dec == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt         = PH_NUMBER;
              word_partial_nxt  = '0;
              byte_position_nxt = '0;
            end
          end else begin
            phase_nxt         = PH_STRLEN;
            word_partial_nxt  = '0;
            byte_position_nxt = '0;
          end
        end
      end else if (byte_position_c != 2'd3) begin
        word_partial_nxt  = word_partial_c | (PW'(data_byte) << {byte_position_c, 3'b000});
        byte_position_nxt = byte_position_c + 2'd1;
        prod_acc_nxt      = (byte_position_c == 2'd0) ? byte_prod_sh : prod_full;
      end else begin
        case (phase_c)
          PH_COUNT: begin
            if (word[WW-1]) begin
              stream_ok_nxt = 1'b0;
            end else begin
              tables_left_nxt = word[CW-1:0];
              if (word == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt         = PH_NUMBER;
                word_partial_nxt  = '0;
                byte_position_nxt = '0;
              end
            end
          end
          PH_NUMBER: begin
            current_table_nxt = word;
            phase_nxt         = PH_ROWS;
            word_partial_nxt  = '0;
            byte_position_nxt = '0;
          end
          PH_ROWS: begin
            if (word[WW-1]) begin
              stream_ok_nxt = 1'b0;
            end else begin
              row_total_nxt     = word[CW-1:0];
              phase_nxt         = PH_COLUMNS;
              word_partial_nxt  = '0;
              byte_position_nxt = '0;
            end
          end
          PH_COLUMNS: begin
            if (word[WW-1] || (prod_full[XW-1:WW] != '0)) begin
              stream_ok_nxt = 1'b0;
            end else begin
              column_total_nxt    = word[CW-1:0];
              cell_total_nxt      = prod_full[WW-1:0];
              cells_emitted_nxt   = '0;
              strings_seen_nxt    = '0;
              row_position_nxt    = '0;
              column_position_nxt = '0;
              if (prod_full[WW-1:0] == '0) begin
                // empty table ends at once
                tables_left_nxt = tables_dec;
                if (tables_dec == '0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt         = PH_NUMBER;
                  word_partial_nxt  = '0;
                  byte_position_nxt = '0;
                end
              end else begin
                phase_nxt         = PH_VALUE;
                word_partial_nxt  = '0;
                byte_position_nxt = '0;
              end
            end
          end
          PH_VALUE: begin
            res.cell_valid    = 1'b1;
            res.table_num     = current_table_c;
            res.row           = row_position_c;
            res.column        = column_position_c;
            res.cell_value    = word;
            cells_emitted_nxt = cells_inc;
            if (column_inc == column_total_c) begin
              column_position_nxt = '0;
              row_position_nxt    = row_position_c + CW'(1);
            end else begin
              column_position_nxt = column_inc;
            end
            phase_nxt         = (cells_inc < cell_total_c) ? PH_VALUE : PH_STRLEN;
            word_partial_nxt  = '0;
            byte_position_nxt = '0;
          end
          PH_STRLEN: begin
            if (word[WW-1]) begin
              stream_ok_nxt = 1'b0;
            end else if (word == '0) begin
              strings_seen_nxt = strings_inc;
              if (strings_inc == cell_total_c) begin
                tables_left_nxt = tables_dec;
                if (tables_dec == '0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt         = PH_NUMBER;
                  word_partial_nxt  = '0;
                  byte_position_nxt = '0;
                end
              end else begin
                phase_nxt         = PH_STRLEN;
                word_partial_nxt  = '0;
                byte_position_nxt = '0;
              end
            end else begin
              string_left_nxt = word[CW-1:0];
              phase_nxt       = PH_STRING;
            end
          end
          default: begin
            phase_nxt = phase_c;
          end
        endcase
        if (!stream_ok_nxt) begin
          res.accepted = 1'b0;
        end
      end
    end
    res.finished = stream_ok_nxt && (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_COUNT;
      tables_left_r     <= '0;
      current_table_r   <= '0;
      row_total_r       <= '0;
      column_total_r    <= '0;
      cell_total_r      <= '0;
      cells_emitted_r   <= '0;
      row_position_r    <= '0;
      column_position_r <= '0;
      strings_seen_r    <= '0;
      string_left_r     <= '0;
      word_partial_r    <= '0;
      byte_position_r   <= '0;
      stream_ok_r       <= 1'b1;
    end else if (in_fire) begin
      phase_r           <= phase_nxt;
      tables_left_r     <= tables_left_nxt;
      current_table_r   <= current_table_nxt;
      row_total_r       <= row_total_nxt;
      column_total_r    <= column_total_nxt;
      cell_total_r      <= cell_total_nxt;
      cells_emitted_r   <= cells_emitted_nxt;
      row_position_r    <= row_position_nxt;
      column_position_r <= column_position_nxt;
      strings_seen_r    <= strings_seen_nxt;
      string_left_r     <= string_left_nxt;
      word_partial_r    <= word_partial_nxt;
      byte_position_r   <= byte_position_nxt;
      stream_ok_r       <= stream_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_acc_r <= prod_acc_nxt;
    end
  end

endmodule

>>> hw/rtl/nts_obuf.sv
// result register between parser and output channel
`timescale 1ns / 1ps

module nts_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  nts_pkg::res_t res_in,
  output logic          can_take,
  output logic          out_valid,
  input  logic          out_ready,
  output nts_pkg::res_t res_out
);

  logic          full_r, full_nxt;
  nts_pkg::res_t data_r;

  assign can_take  = !full_r || out_ready;
  assign full_nxt  = take || (full_r && !out_ready);
  assign out_valid = full_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= res_in;
    end
  end

endmodule
